@@ src/ttrail_pkg.sv @@
// ----------------------------------------------------------------------------
// Track trail store package
// Sizes, codes, table word layouts and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package ttrail_pkg;

	// Table geometry.
	localparam int MAX_SLOTS = 64;
	localparam int MAX_TRAIL = 256;
	localparam int DROP_DIV  = 4;
	localparam int QUARTER   = MAX_TRAIL / DROP_DIV;

	// Derived widths.
	localparam int SLOT_W  = $clog2(MAX_SLOTS);
	localparam int USED_W  = $clog2(MAX_SLOTS + 1);
	localparam int OFF_W   = $clog2(MAX_TRAIL);
	localparam int LEN_W   = $clog2(MAX_TRAIL + 1);
	localparam int PADDR_W = $clog2(MAX_SLOTS * MAX_TRAIL);
	localparam int PREM_W  = $clog2(MAX_SLOTS * MAX_TRAIL + 1);

	// Field widths.
	localparam int KEY_W  = 32;
	localparam int CLS_W  = 8;
	localparam int POS_W  = 24;
	localparam int TIME_W = 32;
	localparam int MS_W   = 23;
	localparam int ACT_W  = 3;
	localparam int FUNC_W = 2;
	localparam int ABS_W  = POS_W + 1;
	localparam int SQ_W   = 2 * ABS_W;
	localparam int MS2_W  = 2 * MS_W;

	// Register port.
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam int REG_IW = CFG_AW - 2;
	localparam logic [REG_IW-1:0] REG_MIN_STEP = REG_IW'(0);
	localparam logic [REG_IW-1:0] REG_RETAIN   = REG_IW'(1);
	localparam logic [TIME_W-1:0] RETAIN_RESET = TIME_W'(60000);

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND = 3'd0,
		ACT_TIP    = 3'd1,
		ACT_DROP   = 3'd2,
		ACT_REJECT = 3'd3,
		ACT_FRAME  = 3'd4,
		ACT_PRUNE  = 3'd5,
		ACT_CLEAR  = 3'd6
	} act_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_BEGIN = 2'd0,
		FN_POINT = 2'd1,
		FN_PRUNE = 2'd2,
		FN_CLEAR = 2'd3
	} func_t;

	typedef enum logic [4:0] {
		S_IDLE, S_BF, S_CLR, S_SRCH, S_CMP, S_TIP, S_D1, S_D2, S_D3, S_APPEND,
		S_PR_META, S_PR_TAKE, S_PR_PT, S_PR_PTD, S_PR_DROP,
		S_MV_META, S_MV_TAKE, S_CP_RD, S_CP_WR, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		PT_TIP = 2'd0,
		PT_K   = 2'd1,
		PT_CP  = 2'd2
	} pt_rsel_t;

	// One slot descriptor as held in the slot table.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [CLS_W-1:0] cls;
		logic [CLS_W-1:0] sts;
		logic [LEN_W-1:0] len;
		logic [OFF_W-1:0] head;
	} meta_t;

	// One trail point as held in the point store.
	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [TIME_W-1:0]       t;
	} point_t;

	localparam int META_W = $bits(meta_t);
	localparam int PT_W   = $bits(point_t);

	typedef struct packed {
		logic     load;
		logic     bf_clr;
		logic     clr_all;
		logic     idx_inc;
		logic     reject;
		logic     open_new;
		logic     take_found;
		logic     tip_wr;
		logic     append;
		logic     pr_take;
		logic     k_inc;
		logic     pr_drop;
		logic     mv_take;
		logic     cp_wr;
		logic     out_load;
		logic     meta_last;
		pt_rsel_t pt_rsel;
	} cmd_t;

	typedef struct packed {
		logic idx_end;
		logic key_match;
		logic full;
		logic len_zero;
		logic near;
		logic has_cut;
		logic k_end;
		logic pt_old;
		logic remove;
		logic move;
		logic cp_last;
		logic out_free;
	} stat_t;

	// Ring offset of entry k after head, for head below and k up to the trail size.
	function automatic logic [OFF_W-1:0] ring_off(input logic [OFF_W-1:0] head,
			input logic [LEN_W-1:0] k);
		logic [LEN_W:0] sum;
		sum = (LEN_W+1)'(head) + (LEN_W+1)'(k);
		if (sum >= (LEN_W+1)'(MAX_TRAIL)) begin
			sum = sum - (LEN_W+1)'(MAX_TRAIL);
		end
		return sum[OFF_W-1:0];
	endfunction

	// Point store address of a ring offset within a slot's trail area.
	function automatic logic [PADDR_W-1:0] pt_addr(input logic [SLOT_W-1:0] s,
			input logic [OFF_W-1:0] off);
		return PADDR_W'(s) * PADDR_W'(MAX_TRAIL) + PADDR_W'(off);
	endfunction

endpackage

@@ src/ttrail_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ttrail_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read; a read returns the value before a same-cycle write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/ttrail_cfg.sv @@
// ----------------------------------------------------------------------------
// Track trail store register port
// Holds min_step and retain_period behind an APB-style slave.
// ----------------------------------------------------------------------------
module ttrail_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ttrail_pkg::CFG_AW-1:0]      paddr,
	input  logic [ttrail_pkg::CFG_DW-1:0]      pwdata,
	output logic [ttrail_pkg::CFG_DW-1:0]      prdata,
	output logic                               pready,
	output logic [ttrail_pkg::MS_W-1:0]        min_step,
	output logic [ttrail_pkg::TIME_W-1:0]      retain_period
);
	import ttrail_pkg::*;

	logic [MS_W-1:0]   min_step_q;
	logic [TIME_W-1:0] retain_q;
	logic [REG_IW-1:0] reg_idx;
	logic              wr;

	assign reg_idx = paddr[CFG_AW-1:2];
	assign wr      = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register writes in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_step_q <= '0;
			retain_q   <= RETAIN_RESET;
		end else if (wr) begin
			case (reg_idx)
				REG_MIN_STEP: min_step_q <= pwdata[MS_W-1:0];
				REG_RETAIN:   retain_q   <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (reg_idx)
			REG_MIN_STEP: prdata = CFG_DW'(min_step_q);
			REG_RETAIN:   prdata = CFG_DW'(retain_q);
			default:      prdata = '0;
		endcase
	end

	assign min_step      = min_step_q;
	assign retain_period = retain_q;

endmodule

@@ src/ttrail_ctrl.sv @@
// ----------------------------------------------------------------------------
// Track trail store controller
// Sequences begin-frame, clear, lookup, tip test, append, prune walks and slot moves.
// ----------------------------------------------------------------------------
module ttrail_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [ttrail_pkg::FUNC_W-1:0] func,
	output logic                          in_stall,
	input  ttrail_pkg::stat_t             stat,
	output ttrail_pkg::cmd_t              cmd
);
	import ttrail_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (func_t'(func))
						FN_BEGIN: state_d = S_BF;
						FN_POINT: state_d = S_SRCH;
						FN_PRUNE: state_d = S_PR_META;
						FN_CLEAR: state_d = S_CLR;
					endcase
				end
			end
			S_BF:      if (stat.idx_end) state_d = S_DONE;
			S_CLR:     state_d = S_DONE;
			S_SRCH: begin
				if (!stat.idx_end) state_d = S_CMP;
				else if (stat.full) state_d = S_DONE;
				else state_d = S_TIP;
			end
			S_CMP:     state_d = stat.key_match ? S_TIP : S_SRCH;
			S_TIP:     state_d = stat.len_zero ? S_APPEND : S_D1;
			S_D1:      state_d = S_D2;
			S_D2:      state_d = S_D3;
			S_D3:      state_d = stat.near ? S_DONE : S_APPEND;
			S_APPEND:  state_d = S_DONE;
			S_PR_META: state_d = stat.idx_end ? S_DONE : S_PR_TAKE;
			S_PR_TAKE: state_d = S_PR_PT;
			S_PR_PT:   state_d = (!stat.has_cut || stat.k_end) ? S_PR_DROP : S_PR_PTD;
			S_PR_PTD:  state_d = stat.pt_old ? S_PR_PT : S_PR_DROP;
			S_PR_DROP: state_d = (stat.remove && stat.move) ? S_MV_META : S_PR_META;
			S_MV_META: state_d = S_MV_TAKE;
			S_MV_TAKE: state_d = S_CP_RD;
			S_CP_RD:   state_d = S_CP_WR;
			S_CP_WR:   state_d = stat.cp_last ? S_PR_META : S_CP_RD;
			S_DONE:    if (stat.out_free) state_d = S_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:    cmd.load = in_valid;
			S_BF:      cmd.bf_clr = !stat.idx_end;
			S_CLR:     cmd.clr_all = 1'b1;
			S_SRCH: begin
				cmd.reject   = stat.idx_end && stat.full;
				cmd.open_new = stat.idx_end && !stat.full;
			end
			S_CMP: begin
				cmd.take_found = stat.key_match;
				cmd.idx_inc    = !stat.key_match;
			end
			S_TIP:     cmd.pt_rsel = PT_TIP;
			S_D1:      ;
			S_D2:      ;
			S_D3:      cmd.tip_wr = stat.near;
			S_APPEND:  cmd.append = 1'b1;
			S_PR_META: ;
			S_PR_TAKE: cmd.pr_take = 1'b1;
			S_PR_PT:   cmd.pt_rsel = PT_K;
			S_PR_PTD:  cmd.k_inc = stat.pt_old;
			S_PR_DROP: begin
				cmd.pr_drop = 1'b1;
				cmd.idx_inc = !stat.remove;
			end
			S_MV_META: cmd.meta_last = 1'b1;
			S_MV_TAKE: cmd.mv_take = 1'b1;
			S_CP_RD:   cmd.pt_rsel = PT_CP;
			S_CP_WR:   cmd.cp_wr = 1'b1;
			S_DONE:    cmd.out_load = stat.out_free;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

@@ src/ttrail_dp.sv @@
// ----------------------------------------------------------------------------
// Track trail store datapath
// Slot table, point store, distance pipeline, counters and result register.
// ----------------------------------------------------------------------------
module ttrail_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ttrail_pkg::cmd_t                     cmd,
	output ttrail_pkg::stat_t                    stat,
	input  logic [ttrail_pkg::FUNC_W-1:0]        func,
	input  logic signed [ttrail_pkg::KEY_W-1:0]  track_key,
	input  logic [ttrail_pkg::CLS_W-1:0]         track_class,
	input  logic [ttrail_pkg::CLS_W-1:0]         track_status,
	input  logic signed [ttrail_pkg::POS_W-1:0]  pos_x,
	input  logic signed [ttrail_pkg::POS_W-1:0]  pos_y,
	input  logic [ttrail_pkg::TIME_W-1:0]        time_ms,
	input  logic [ttrail_pkg::MS_W-1:0]          min_step,
	input  logic [ttrail_pkg::TIME_W-1:0]        retain_period,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic [ttrail_pkg::ACT_W-1:0]         action,
	output logic [ttrail_pkg::SLOT_W-1:0]        slot,
	output logic [ttrail_pkg::LEN_W-1:0]         trail_length,
	output logic [ttrail_pkg::USED_W-1:0]        slots_in_use,
	output logic [ttrail_pkg::USED_W-1:0]        slots_removed,
	output logic [ttrail_pkg::PREM_W-1:0]        points_removed
);
	import ttrail_pkg::*;

	// Latched item.
	logic [KEY_W-1:0]        key_q;
	logic [CLS_W-1:0]        cls_q, sts_q;
	logic signed [POS_W-1:0] x_q, y_q;
	logic [TIME_W-1:0]       t_q, cutoff_q;
	logic                    has_cut_q;

	// Counters and working slot.
	logic [USED_W-1:0] used_q, idx_q, srem_q;
	logic [LEN_W-1:0]  k_q, tlen_q;
	logic [PREM_W-1:0] prem_q;
	logic [SLOT_W-1:0] slot_q;
	act_t              act_q;
	meta_t             meta_q;
	logic              alive_q;

	// Distance pipeline.
	logic [ABS_W-1:0] ax_s1, ay_s1;
	logic [SQ_W-1:0]  sqx_s2, sqy_s2;
	logic [MS2_W-1:0] ms2_s2;

	// Result register.
	logic              ov_q;
	act_t              oact_q;
	logic [SLOT_W-1:0] oslot_q;
	logic [LEN_W-1:0]  otlen_q;
	logic [USED_W-1:0] oused_q, osrem_q;
	logic [PREM_W-1:0] oprem_q;

	// Memory ports.
	logic              meta_we, alive_we, alive_wdata, alive_rdata, pt_we;
	logic [META_W-1:0] meta_wdata, meta_rdata;
	logic [SLOT_W-1:0] meta_raddr, idx_s;
	logic [PADDR_W-1:0] pt_raddr, pt_waddr;
	logic [PT_W-1:0]   pt_wdata, pt_rdata;

	meta_t             meta_rd, app_meta, drop_meta, found_meta;
	point_t            pt_rd;
	logic [OFF_W-1:0]  tip_off, k_off, app_head, app_off;
	logic [LEN_W-1:0]  app_len;
	logic              trail_full;
	logic signed [ABS_W-1:0] dx, dy;
	logic [ABS_W-1:0]  ax_w, ay_w;
	logic [SQ_W-1:0]   sqx_w, sqy_w;
	logic [MS2_W-1:0]  ms2_w;
	logic [SQ_W:0]     dist_sum;

	assign idx_s   = idx_q[SLOT_W-1:0];
	assign meta_rd = meta_t'(meta_rdata);
	assign pt_rd   = point_t'(pt_rdata);

	// Ring positions for the tip, the prune cursor and an append.
	always_comb begin
		tip_off    = ring_off(meta_q.head, meta_q.len - LEN_W'(1));
		k_off      = ring_off(meta_q.head, k_q);
		trail_full = meta_q.len >= LEN_W'(MAX_TRAIL);
		app_head   = trail_full ? ring_off(meta_q.head, LEN_W'(QUARTER)) : meta_q.head;
		app_len    = trail_full ? meta_q.len - LEN_W'(QUARTER) : meta_q.len;
		app_off    = ring_off(app_head, app_len);
		app_meta      = meta_q;
		app_meta.head = app_head;
		app_meta.len  = app_len + LEN_W'(1);
		drop_meta      = meta_q;
		drop_meta.head = k_off;
		drop_meta.len  = meta_q.len - k_q;
		found_meta     = meta_rd;
		found_meta.cls = cls_q;
		found_meta.sts = sts_q;
	end

	// Slot table and point store ports.
	always_comb begin
		meta_raddr = cmd.meta_last ? used_q[SLOT_W-1:0] : idx_s;
		meta_we    = cmd.tip_wr || cmd.append || cmd.pr_drop || cmd.mv_take;
		if (cmd.mv_take) begin
			meta_wdata = meta_rdata;
		end else if (cmd.append) begin
			meta_wdata = META_W'(app_meta);
		end else if (cmd.pr_drop) begin
			meta_wdata = META_W'(drop_meta);
		end else begin
			meta_wdata = META_W'(meta_q);
		end
		alive_we    = cmd.tip_wr || cmd.append || cmd.bf_clr || cmd.mv_take;
		alive_wdata = cmd.mv_take ? alive_rdata : !cmd.bf_clr;

		unique case (cmd.pt_rsel)
			PT_TIP:  pt_raddr = pt_addr(idx_s, tip_off);
			PT_K:    pt_raddr = pt_addr(idx_s, k_off);
			PT_CP:   pt_raddr = pt_addr(used_q[SLOT_W-1:0], k_q[OFF_W-1:0]);
			default: pt_raddr = pt_addr(idx_s, tip_off);
		endcase
		pt_we = cmd.tip_wr || cmd.append || cmd.cp_wr;
		if (cmd.cp_wr) begin
			pt_waddr = pt_addr(idx_s, k_q[OFF_W-1:0]);
			pt_wdata = pt_rdata;
		end else begin
			pt_waddr = cmd.tip_wr ? pt_addr(idx_s, tip_off) : pt_addr(idx_s, app_off);
			pt_wdata = {x_q, y_q, t_q};
		end
	end

	ttrail_ram #(.WIDTH(META_W), .DEPTH(MAX_SLOTS)) u_meta (
		.clk(clk), .we(meta_we), .waddr(idx_s), .wdata(meta_wdata),
		.raddr(meta_raddr), .rdata(meta_rdata)
	);

	ttrail_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_alive (
		.clk(clk), .we(alive_we), .waddr(idx_s), .wdata(alive_wdata),
		.raddr(meta_raddr), .rdata(alive_rdata)
	);

	ttrail_ram #(.WIDTH(PT_W), .DEPTH(MAX_SLOTS * MAX_TRAIL)) u_points (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);

	// Distance to the tip: absolute differences, then squares, then the compare.
	always_comb begin
		dx    = ABS_W'(x_q) - ABS_W'(pt_rd.x);
		dy    = ABS_W'(y_q) - ABS_W'(pt_rd.y);
		ax_w  = dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
		ay_w  = dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
		sqx_w = ax_s1 * ax_s1;
		sqy_w = ay_s1 * ay_s1;
		ms2_w = min_step * min_step;
		dist_sum = (SQ_W+1)'(sqx_s2) + (SQ_W+1)'(sqy_s2);
	end

	always_ff @(posedge clk) begin
		ax_s1  <= ax_w;
		ay_s1  <= ay_w;
		sqx_s2 <= sqx_w;
		sqy_s2 <= sqy_w;
		ms2_s2 <= ms2_w;
	end

	// Status back to the controller.
	always_comb begin
		stat.idx_end   = idx_q >= used_q;
		stat.key_match = meta_rd.key == key_q;
		stat.full      = used_q == USED_W'(MAX_SLOTS);
		stat.len_zero  = meta_q.len == '0;
		stat.near      = dist_sum < (SQ_W+1)'(ms2_s2);
		stat.has_cut   = has_cut_q;
		stat.k_end     = k_q == meta_q.len;
		stat.pt_old    = pt_rd.t < cutoff_q;
		stat.remove    = (drop_meta.len == '0) && !alive_q;
		stat.move      = (used_q - USED_W'(1)) != idx_q;
		stat.cp_last   = k_q == LEN_W'(MAX_TRAIL - 1);
		stat.out_free  = !ov_q || !out_stall;
	end

	// Control counters and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			idx_q  <= '0;
			k_q    <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (cmd.clr_all) begin
				used_q <= '0;
			end else if (cmd.open_new) begin
				used_q <= used_q + USED_W'(1);
			end else if (cmd.pr_drop && stat.remove) begin
				used_q <= used_q - USED_W'(1);
			end

			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.bf_clr || cmd.idx_inc) begin
				idx_q <= idx_q + USED_W'(1);
			end

			if (cmd.pr_take || cmd.mv_take) begin
				k_q <= '0;
			end else if (cmd.k_inc || cmd.cp_wr) begin
				k_q <= k_q + LEN_W'(1);
			end

			if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Item capture, working slot and result accumulation.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q     <= track_key;
			cls_q     <= track_class;
			sts_q     <= track_status;
			x_q       <= pos_x;
			y_q       <= pos_y;
			t_q       <= time_ms;
			has_cut_q <= time_ms > retain_period;
			cutoff_q  <= time_ms - retain_period;
			slot_q    <= '0;
			tlen_q    <= '0;
			srem_q    <= '0;
			prem_q    <= '0;
			unique case (func_t'(func))
				FN_BEGIN: act_q <= ACT_FRAME;
				FN_POINT: act_q <= ACT_APPEND;
				FN_PRUNE: act_q <= ACT_PRUNE;
				FN_CLEAR: act_q <= ACT_CLEAR;
			endcase
		end
		if (cmd.reject) begin
			act_q <= ACT_REJECT;
		end
		if (cmd.open_new) begin
			meta_q <= '{key: key_q, cls: cls_q, sts: sts_q, len: '0, head: '0};
		end
		if (cmd.take_found) begin
			meta_q <= found_meta;
		end
		if (cmd.tip_wr) begin
			act_q  <= ACT_TIP;
			slot_q <= idx_s;
			tlen_q <= meta_q.len;
		end
		if (cmd.append) begin
			act_q  <= trail_full ? ACT_DROP : ACT_APPEND;
			prem_q <= trail_full ? PREM_W'(QUARTER) : '0;
			slot_q <= idx_s;
			tlen_q <= app_meta.len;
			meta_q <= app_meta;
		end
		if (cmd.pr_take) begin
			meta_q  <= meta_rd;
			alive_q <= alive_rdata;
		end
		if (cmd.pr_drop) begin
			meta_q <= drop_meta;
			prem_q <= prem_q + PREM_W'(k_q);
			if (stat.remove) begin
				srem_q <= srem_q + USED_W'(1);
			end
		end
		if (cmd.out_load) begin
			oact_q  <= act_q;
			oslot_q <= slot_q;
			otlen_q <= tlen_q;
			oused_q <= used_q;
			osrem_q <= srem_q;
			oprem_q <= prem_q;
		end
	end

	assign out_valid      = ov_q;
	assign action         = oact_q;
	assign slot           = oslot_q;
	assign trail_length   = otlen_q;
	assign slots_in_use   = oused_q;
	assign slots_removed  = osrem_q;
	assign points_removed = oprem_q;

endmodule

@@ src/track_trail_history_store.sv @@
// Begin-frame walks the slots in use; a point walks the keys over the slot table, then
// passes a three-stage distance pipeline.
// Prune walks each slot and its dropped points; a slot that is refilled from the last one
// is copied through the point store one entry at a time, each read and then written.
// One word is worked at a time; the next is taken once the result sits in the output register.
// Reset empties the table at once; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
// Track trail history store
// Keyed table of point trails with tip update, quarter drop and age pruning.
// ----------------------------------------------------------------------------
module track_trail_history_store (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ttrail_pkg::CFG_AW-1:0]        paddr,
	input  logic [ttrail_pkg::CFG_DW-1:0]        pwdata,
	output logic [ttrail_pkg::CFG_DW-1:0]        prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ttrail_pkg::FUNC_W-1:0]        func,
	input  logic signed [ttrail_pkg::KEY_W-1:0]  track_key,
	input  logic [ttrail_pkg::CLS_W-1:0]         track_class,
	input  logic [ttrail_pkg::CLS_W-1:0]         track_status,
	input  logic signed [ttrail_pkg::POS_W-1:0]  pos_x,
	input  logic signed [ttrail_pkg::POS_W-1:0]  pos_y,
	input  logic [ttrail_pkg::TIME_W-1:0]        time_ms,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ttrail_pkg::ACT_W-1:0]         action,
	output logic [ttrail_pkg::SLOT_W-1:0]        slot,
	output logic [ttrail_pkg::LEN_W-1:0]         trail_length,
	output logic [ttrail_pkg::USED_W-1:0]        slots_in_use,
	output logic [ttrail_pkg::USED_W-1:0]        slots_removed,
	output logic [ttrail_pkg::PREM_W-1:0]        points_removed
);
	import ttrail_pkg::*;

	logic [MS_W-1:0]   min_step;
	logic [TIME_W-1:0] retain_period;
	cmd_t              cmd;
	stat_t             stat;

	// Register port.
	ttrail_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.min_step(min_step), .retain_period(retain_period)
	);

	// Sequencer.
	ttrail_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .func(func),
		.in_stall(in_stall), .stat(stat), .cmd(cmd)
	);

	// Tables, arithmetic and result register.
	ttrail_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .func(func),
		.track_key(track_key), .track_class(track_class), .track_status(track_status),
		.pos_x(pos_x), .pos_y(pos_y), .time_ms(time_ms),
		.min_step(min_step), .retain_period(retain_period),
		.out_stall(out_stall), .out_valid(out_valid), .action(action), .slot(slot),
		.trail_length(trail_length), .slots_in_use(slots_in_use),
		.slots_removed(slots_removed), .points_removed(points_removed)
	);

endmodule
